// File: hw/rtl/double_ended_queue_engine_unit_macros.svh
// assertion macros used by the queue engine controller
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define DEQ_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DEQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 11;
  localparam int COUNT_W  = 11;
  localparam int VALUE_W  = 32;
  localparam int READ_W   = 32;
  localparam int FILL_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_ERASE      = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic rd_capture;
    logic shift_rd;
    logic shift_wr;
    logic fill_wr;
    logic load_res;
  } deq_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [STATUS_W-1:0] st;
    logic                cnt_zero;
    logic                mv_zero;
    logic                mv_last;
    logic                fill_last;
    logic                res_free;
  } deq_sts_t;

endpackage

// File: hw/rtl/deq_if.sv
interface deq_req_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  index;
  logic [COUNT_W-1:0]  count;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, action, index, count, value, input ready);
  modport sink (input valid, action, index, count, value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [READ_W-1:0]   read_value;
  logic [FILL_W-1:0]   fill_level;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_value, fill_level, status, input ready);
  modport sink (input valid, read_value, fill_level, status, output ready);
endinterface

// File: hw/rtl/deq_dp.sv
module deq_dp #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  deq_pkg::deq_cmd_t         cmd,
  output deq_pkg::deq_sts_t         sts,
  input  logic [deq_pkg::ACTION_W-1:0] in_action,
  input  logic [deq_pkg::INDEX_W-1:0]  in_index,
  input  logic [deq_pkg::COUNT_W-1:0]  in_count,
  input  logic [deq_pkg::VALUE_W-1:0]  in_value,
  output logic                      res_valid,
  input  logic                      out_ready,
  output logic [deq_pkg::READ_W-1:0]   res_rd,
  output logic [deq_pkg::FILL_W-1:0]   res_fill,
  output logic [deq_pkg::STATUS_W-1:0] res_st
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = ((OW > INDEX_W) ? OW : INDEX_W) + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  logic [ACTION_W-1:0]   act_q;
  logic [INDEX_W-1:0]    idx_q;
  logic [COUNT_W-1:0]    cnt_raw_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [AW-1:0] head;
  logic [OW-1:0] occ;
  logic [OW-1:0] src;
  logic [OW-1:0] mv_cnt;
  logic [OW-1:0] cnt;
  logic [OW-1:0] fill_off;

  logic [READ_W-1:0]   pend_rd;
  logic [STATUS_W-1:0] pend_st;

  logic [CW-1:0]       idx_w, cnt_w, occ_w, dep_w, moves_w;
  logic [OW-1:0]       idx_o, cnt_o, occ_m1, dst;
  logic [AW-1:0]       head_dec, head_inc;
  logic [STATUS_W-1:0] st_c;
  logic                is_ins, exec_ok;
  logic                we;
  logic [AW-1:0]       wa, ra;
  logic [DATA_WIDTH-1:0] wd;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = (OW + 1)'(base) + (OW + 1)'(off);
    if (sum >= (OW + 1)'(DEPTH)) begin
      sum = sum - (OW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign idx_w   = CW'(idx_q);
  assign cnt_w   = CW'(cnt_raw_q);
  assign occ_w   = CW'(occ);
  assign dep_w   = CW'(DEPTH);
  assign idx_o   = idx_w[OW-1:0];
  assign cnt_o   = cnt_w[OW-1:0];
  assign occ_m1  = occ - 1'b1;
  assign is_ins  = (act_q == ACT_INSERT);
  assign moves_w = is_ins ? (occ_w - idx_w) : (occ_w - idx_w - cnt_w);
  assign dst     = is_ins ? (src + cnt) : (src - cnt);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  always_comb begin
    st_c = ST_OK;
    case (act_q)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (occ_w == dep_w) st_c = ST_FULL;
      end
      ACT_POP_BACK, ACT_POP_FRONT: begin
        if (occ == '0) st_c = ST_EMPTY;
      end
      ACT_READ: begin
        if (idx_w >= occ_w) st_c = ST_RANGE;
      end
      ACT_INSERT: begin
        if (idx_w > occ_w) st_c = ST_RANGE;
        else if (cnt_w > dep_w - occ_w) st_c = ST_FULL;
      end
      ACT_ERASE: begin
        if (idx_w > occ_w || cnt_w > occ_w - idx_w) st_c = ST_RANGE;
      end
      default: st_c = ST_OK;
    endcase
  end

  assign exec_ok = cmd.exec && (st_c == ST_OK);

  always_comb begin
    we = 1'b0;
    wa = wrap(head, fill_off);
    wd = val_q;
    if (exec_ok && act_q == ACT_PUSH_BACK) begin
      we = 1'b1;
      wa = wrap(head, occ);
    end else if (exec_ok && act_q == ACT_PUSH_FRONT) begin
      we = 1'b1;
      wa = head_dec;
    end else if (cmd.shift_wr) begin
      we = 1'b1;
      wa = wrap(head, dst);
      wd = rd_data;
    end else if (cmd.fill_wr) begin
      we = 1'b1;
    end
  end

  always_comb begin
    ra = wrap(head, src);
    if (cmd.exec) begin
      case (act_q)
        ACT_POP_BACK:  ra = wrap(head, occ_m1);
        ACT_POP_FRONT: ra = head;
        ACT_READ:      ra = wrap(head, idx_o);
        default:       ra = wrap(head, src);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (exec_ok) begin
        case (act_q)
          ACT_PUSH_BACK: occ <= occ + 1'b1;
          ACT_PUSH_FRONT: begin
            head <= head_dec;
            occ  <= occ + 1'b1;
          end
          ACT_POP_BACK: occ <= occ_m1;
          ACT_POP_FRONT: begin
            head <= head_inc;
            occ  <= occ_m1;
          end
          ACT_INSERT: occ <= occ + cnt_o;
          ACT_ERASE:  occ <= occ - cnt_o;
          ACT_CLEAR:  occ <= '0;
          default: ;
        endcase
      end
      if (cmd.load_res) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q     <= in_action;
      idx_q     <= in_index;
      cnt_raw_q <= in_count;
      val_q     <= DATA_WIDTH'(in_value);
    end
    if (cmd.exec) begin
      pend_st  <= st_c;
      pend_rd  <= '0;
      mv_cnt   <= moves_w[OW-1:0];
      src      <= is_ins ? occ_m1 : idx_o + cnt_o;
      cnt      <= cnt_o;
      fill_off <= idx_o;
    end
    if (cmd.rd_capture) begin
      pend_rd <= READ_W'(rd_data);
    end
    if (cmd.shift_wr) begin
      src    <= is_ins ? src - 1'b1 : src + 1'b1;
      mv_cnt <= mv_cnt - 1'b1;
    end
    if (cmd.fill_wr) begin
      fill_off <= fill_off + 1'b1;
      cnt      <= cnt - 1'b1;
    end
    if (cmd.load_res) begin
      res_rd   <= pend_rd;
      res_fill <= FILL_W'(occ);
      res_st   <= pend_st;
    end
  end

  assign sts.act       = act_q;
  assign sts.st        = st_c;
  assign sts.cnt_zero  = (cnt_raw_q == '0);
  assign sts.mv_zero   = (moves_w == '0);
  assign sts.mv_last   = (mv_cnt == OW'(1));
  assign sts.fill_last = (cnt == OW'(1));
  assign sts.res_free  = !res_valid || out_ready;

endmodule

// File: hw/rtl/deq_ctrl.sv
`include "double_ended_queue_engine_unit_macros.svh"

module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output deq_pkg::deq_cmd_t cmd,
  input  deq_pkg::deq_sts_t sts
);
  import deq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDDONE = 3'd2;
  localparam logic [2:0] S_SHRD   = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.st != ST_OK) begin
          state_next = S_DONE;
        end else begin
          case (sts.act)
            ACT_POP_BACK, ACT_POP_FRONT, ACT_READ: state_next = S_RDDONE;
            ACT_INSERT: begin
              if (sts.cnt_zero) state_next = S_DONE;
              else if (sts.mv_zero) state_next = S_FILL;
              else state_next = S_SHRD;
            end
            ACT_ERASE: begin
              if (sts.cnt_zero || sts.mv_zero) state_next = S_DONE;
              else state_next = S_SHRD;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RDDONE: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_SHRD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHWR;
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        if (sts.mv_last) begin
          state_next = (sts.act == ACT_INSERT) ? S_FILL : S_DONE;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.load_res = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DEQ_ASSERT_NOW(a_load_needs_room, cmd.load_res, sts.res_free, "result loaded into a busy slot")
  `DEQ_ASSERT_NEXT(a_accept_to_exec, cmd.accept, state == S_EXEC, "accepted item not executed")
  `DEQ_ASSERT_NOW(a_write_after_read, state == S_SHWR, $past(state) == S_SHRD, "shift write without read")
  `DEQ_ASSERT_NOW(a_fill_only_insert, state == S_FILL, sts.act == ACT_INSERT, "fill outside insert")

endmodule

// File: hw/rtl/double_ended_queue_engine_unit.sv
// double-ended queue of DATA_WIDTH-bit words in a ring of DEPTH entries
// req (sink): action, index, count, value; a transaction is valid && ready
// rsp (source): read_value, fill_level, status, one transaction per request
// actions: push/pop at either end, read at index, insert count copies of
// value before index, erase count words from index, clear
// a request is taken only while the controller is idle; the result sits in
// an output register, so the next request is taken while it waits
// push, clear and failed requests go through accept, execute and result load;
// pop and read add a step that captures the registered memory read
// insert adds a shift read and a shift write per moved word, then a fill write
// per copy; erase adds only the shifts; moved is the number of words behind the
// position, or behind the erased range for erase
// reset clears head, fill count and the result valid flag; the ring memory is
// not cleared, no clearing pass is needed
// while rsp is stalled the finished result waits and the controller holds
// the following request before its result load
module double_ended_queue_engine_unit #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;
  logic     res_valid;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (req.action),
    .in_index  (req.index),
    .in_count  (req.count),
    .in_value  (req.value),
    .res_valid (res_valid),
    .out_ready (rsp.ready),
    .res_rd    (rsp.read_value),
    .res_fill  (rsp.fill_level),
    .res_st    (rsp.status)
  );

  assign rsp.valid = res_valid;

endmodule
